### rtl/core/i64a_pkg.sv
// shared types, constants and a helper function for the int64 to decimal text unit
// no dependencies; compiled first
`default_nettype none

package i64a_pkg;

    // magnitude width and number of decimal digits that 2**63 needs
    localparam int MAG_W      = 64;
    localparam int NUM_DIGITS = 19;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int CNT_W      = $clog2(MAG_W);
    localparam int REM_W      = $clog2(NUM_DIGITS + 1);

    // ascii codes
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    typedef logic [BCD_W-1:0] bcd_t;
    typedef logic [MAG_W-1:0] mag_t;

    // converter result towards the emitter
    typedef struct packed {
        logic done;
        bcd_t bcd;
    } conv_result_t;

    // emitter status back to the sequencer
    typedef struct packed {
        logic busy;
        logic finish;
    } emit_status_t;

    // add 3 to every bcd digit of 5 or more, digits are independent
    function automatic bcd_t bcd_adjust(input bcd_t bcd);
        bcd_t res;
        res = bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[i*4 +: 4] >= 4'd5) begin
                res[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/core/i64a_in_if.sv
// input channel: one signed 64-bit value per transaction
// no dependencies
`default_nettype none

interface i64a_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

### rtl/core/i64a_out_if.sv
// output channel: one ascii byte per transaction, last byte of a value flagged
// no dependencies
`default_nettype none

interface i64a_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

### rtl/core/int64_to_decimal_ascii_unit.sv
// signed 64-bit integer to decimal ascii text, one byte per output transaction
// flow: the value is converted bit-serially, loaded into the emitter and its leading zeros are skipped,
// then the sign if negative and the digits are registered one byte at a time as the sink takes them
// a new value is accepted only once the last byte is registered and the unit is idle again
// reset: asynchronous active low, clears all control state, no output pending
`default_nettype none

module int64_to_decimal_ascii_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    i64a_in_if.sink    item,
    i64a_out_if.source text
);
    import i64a_pkg::*;

    localparam logic [1:0] SEQ_IDLE = 2'd0;
    localparam logic [1:0] SEQ_CONV = 2'd1;
    localparam logic [1:0] SEQ_EMIT = 2'd2;

    logic [1:0]   seq_reg, seq_next;
    logic         neg_reg, neg_next;
    logic         start;
    mag_t         magnitude;
    conv_result_t conv;
    emit_status_t emit_st;

    // two's complement magnitude, most negative value stays correct as unsigned
    assign magnitude = item.value[63] ? (~item.value + 64'd1) : item.value;
    assign item.ready = (seq_reg == SEQ_IDLE);
    assign start      = item.valid && item.ready;

    // sequencer over convert and emit
    always_comb
    begin
        seq_next = seq_reg;
        neg_next = neg_reg;
        unique case (seq_reg)
            SEQ_IDLE:
            begin
                if (start) begin
                    neg_next = item.value[63];
                    seq_next = SEQ_CONV;
                end
            end
            SEQ_CONV:
            begin
                if (conv.done) begin
                    seq_next = SEQ_EMIT;
                end
            end
            SEQ_EMIT:
            begin
                if (emit_st.finish) begin
                    seq_next = SEQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seq_reg <= SEQ_IDLE;
            neg_reg <= 1'b0;
        end else begin
            seq_reg <= seq_next;
            neg_reg <= neg_next;
        end
    end

    // bit-serial binary to bcd
    i64a_dabble u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .magnitude (magnitude),
        .result    (conv)
    );

    // byte emitter
    i64a_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (conv.done && !emit_st.busy),
        .negative (neg_reg),
        .bcd      (conv.bcd),
        .status   (emit_st),
        .text     (text)
    );

endmodule

`default_nettype wire

### rtl/core/i64a_dabble.sv
// iterative shift-and-add-3 binary to bcd converter, one bit per cycle
// depends on i64a_pkg
`default_nettype none

module i64a_dabble (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire i64a_pkg::mag_t        magnitude,
    output i64a_pkg::conv_result_t     result
);
    import i64a_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    mag_t             bin_reg, bin_next;
    bcd_t             bcd_reg, bcd_next;
    bcd_t             bcd_adj;

    // single adjust unit on the current digits
    assign bcd_adj = bcd_adjust(bcd_reg);

    // sequencing of the 64 shift steps
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bin_next  = magnitude;
            bcd_next  = '0;
        end else if (busy_reg) begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[MAG_W-1]};
            bin_next = {bin_reg[MAG_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MAG_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign result.done = done_reg;
    assign result.bcd  = bcd_reg;

endmodule

`default_nettype wire

### rtl/core/i64a_emit.sv
// leading-zero skip and serial byte emitter with output register
// depends on i64a_pkg and i64a_out_if
`default_nettype none

module i64a_emit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire logic                 negative,
    input  wire i64a_pkg::bcd_t       bcd,
    output i64a_pkg::emit_status_t    status,
    i64a_out_if.source                text
);
    import i64a_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SKIP = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic             sign_reg, sign_next;
    logic             valid_reg, valid_next;
    logic             finish_reg, finish_next;
    bcd_t             digits_reg, digits_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;
    logic [3:0]       top_digit;
    logic             slot_free;

    assign top_digit = digits_reg[BCD_W-1 -: 4];
    assign slot_free = !valid_reg || text.ready;

    // skip leading zeros, then hand out sign and digits
    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        sign_next   = sign_reg;
        digits_next = digits_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        finish_next = 1'b0;
        valid_next  = valid_reg && !text.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load) begin
                    digits_next = bcd;
                    rem_next    = REM_W'(NUM_DIGITS);
                    sign_next   = negative;
                    state_next  = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (top_digit == 4'd0 && rem_reg > REM_W'(1)) begin
                    digits_next = {digits_reg[BCD_W-5:0], 4'd0};
                    rem_next    = rem_reg - 1'b1;
                end else begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (slot_free) begin
                    valid_next = 1'b1;
                    if (sign_reg) begin
                        char_next = ASCII_MINUS;
                        last_next = 1'b0;
                        sign_next = 1'b0;
                    end else begin
                        char_next   = ASCII_ZERO + {4'd0, top_digit};
                        last_next   = (rem_reg == REM_W'(1));
                        digits_next = {digits_reg[BCD_W-5:0], 4'd0};
                        rem_next    = rem_reg - 1'b1;
                        if (rem_reg == REM_W'(1)) begin
                            state_next  = ST_IDLE;
                            finish_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            valid_reg  <= 1'b0;
            finish_reg <= 1'b0;
            sign_reg   <= 1'b0;
            rem_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            finish_reg <= finish_next;
            sign_reg   <= sign_next;
            rem_reg    <= rem_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign text.valid     = valid_reg;
    assign text.char_code = char_reg;
    assign text.last_char = last_reg;

    assign status.busy   = (state_reg != ST_IDLE);
    assign status.finish = finish_reg;

endmodule

`default_nettype wire
